>>> sv/hsl2rgb_pkg.sv
// shared constants for the hsl to rgb converter
package hsl2rgb_pkg;

  localparam int HUE_W   = 16;
  localparam int CFG_W   = 17;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 1;

  localparam int PIPE_DEPTH = 4;

  localparam logic [IDX_W-1:0] REG_SATURATION = 1'b0;
  localparam logic [IDX_W-1:0] REG_LIGHTNESS  = 1'b1;

  localparam logic [CFG_W-1:0] SATURATION_RST = 17'd32768;
  localparam logic [CFG_W-1:0] LIGHTNESS_RST  = 17'd39322;

endpackage

>>> sv/hsl_to_rgb_converter_core.sv
// hsl to rgb converter core: four-stage pipeline from hue beat to rgb beat
//
// Converts one hue per clock into an 8-bit red/green/blue triple, using the
// saturation and lightness held in the two configuration registers. A hue is
// taken whenever start is high and busy is low; busy is high only during
// reset. The result appears on red/green/blue with done high for one cycle,
// once the hue has passed through the four register stages:
// distance terms, chroma multiply, sector-ramp multiply, channel
// form/saturate. Every cycle can carry a new hue, so throughput is one beat
// per clock, and the receiver cannot stall the pipeline. Write saturation and
// lightness only while no beat is in flight.
module hsl_to_rgb_converter_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]   hue,
  output logic                            done,
  output logic [hsl2rgb_pkg::CHAN_W-1:0]  red,
  output logic [hsl2rgb_pkg::CHAN_W-1:0]  green,
  output logic [hsl2rgb_pkg::CHAN_W-1:0]  blue,
  input  logic                            wr_en,
  input  logic [hsl2rgb_pkg::IDX_W-1:0]   wr_index,
  input  logic [hsl2rgb_pkg::CFG_W-1:0]   wr_data
);

  localparam int F  = FRACTION_BITS;
  localparam int W  = F + 1;
  localparam int CW = (W > hsl2rgb_pkg::CFG_W) ? W : hsl2rgb_pkg::CFG_W;
  localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

  function automatic logic [hsl2rgb_pkg::CHAN_W-1:0] chan_of(input logic [F+2:0] v);
    logic [F+2:0] sh;
    sh = v >> (F - 7);
    chan_of = (sh > (F+3)'(255)) ? {hsl2rgb_pkg::CHAN_W{1'b1}} : sh[7:0];
  endfunction

  // configuration registers
  logic [hsl2rgb_pkg::CFG_W-1:0] saturation;
  logic [hsl2rgb_pkg::CFG_W-1:0] lightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= hsl2rgb_pkg::SATURATION_RST;
      lightness  <= hsl2rgb_pkg::LIGHTNESS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        hsl2rgb_pkg::REG_SATURATION: saturation <= wr_data;
        hsl2rgb_pkg::REG_LIGHTNESS:  lightness  <= wr_data;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // stage 1: clamp, distance terms, sector
  logic [W-1:0]   s_cl;
  logic [W-1:0]   l_cl;
  logic [F+1:0]   two_l;
  logic [W-1:0]   l_dist;
  logic [F-1:0]   hue_f;
  logic [F+2:0]   hp;
  logic [W-1:0]   wrapped;
  logic [W-1:0]   tdist;

  always_comb begin
    s_cl  = (CW'(saturation) > CW'(ONE)) ? ONE : W'(saturation);
    l_cl  = (CW'(lightness) > CW'(ONE)) ? ONE : W'(lightness);
    two_l = {l_cl, 1'b0};
    if (two_l >= (F+2)'(ONE)) begin
      l_dist = W'(two_l - (F+2)'(ONE));
    end else begin
      l_dist = W'((F+2)'(ONE) - two_l);
    end
    hue_f   = F'(hue);
    hp      = (F+3)'(hue_f) * (F+3)'(6);
    wrapped = hp[F:0];
    if (wrapped >= ONE) begin
      tdist = wrapped - ONE;
    end else begin
      tdist = ONE - wrapped;
    end
  end

  logic         v1;
  logic [W-1:0] s1;
  logic [W-1:0] omd1;
  logic [W-1:0] omt1;
  logic [2:0]   sector1;
  logic [F+1:0] two_l1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    s1      <= s_cl;
    omd1    <= ONE - l_dist;
    omt1    <= ONE - tdist;
    sector1 <= hp[F+2:F];
    two_l1  <= two_l;
  end

  // stage 2: chroma
  logic [2*W-1:0] chroma_prod;
  assign chroma_prod = (2*W)'(omd1) * (2*W)'(s1);

  logic         v2;
  logic [W-1:0] chroma2;
  logic [W-1:0] omt2;
  logic [2:0]   sector2;
  logic [F+1:0] two_l2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    chroma2 <= chroma_prod[F+W-1:F];
    omt2    <= omt1;
    sector2 <= sector1;
    two_l2  <= two_l1;
  end

  // stage 3: ramp value and offset
  logic [2*W-1:0] x_prod;
  assign x_prod = (2*W)'(chroma2) * (2*W)'(omt2);

  logic         v3;
  logic [W-1:0] xval3;
  logic [W-1:0] chroma3;
  logic [F+1:0] m2_3;
  logic [2:0]   sector3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    xval3   <= x_prod[F+W-1:F];
    chroma3 <= chroma2;
    m2_3    <= two_l2 - (F+2)'(chroma2);
    sector3 <= sector2;
  end

  // stage 4: channel values and sector order
  logic [hsl2rgb_pkg::CHAN_W-1:0] vc;
  logic [hsl2rgb_pkg::CHAN_W-1:0] vx;
  logic [hsl2rgb_pkg::CHAN_W-1:0] vm;
  logic [hsl2rgb_pkg::CHAN_W-1:0] r_next;
  logic [hsl2rgb_pkg::CHAN_W-1:0] g_next;
  logic [hsl2rgb_pkg::CHAN_W-1:0] b_next;

  always_comb begin
    vc = chan_of((F+3)'({chroma3, 1'b0}) + (F+3)'(m2_3));
    vx = chan_of((F+3)'({xval3, 1'b0}) + (F+3)'(m2_3));
    vm = chan_of((F+3)'(m2_3));
    case (sector3)
      3'd0: begin r_next = vc; g_next = vx; b_next = vm; end
      3'd1: begin r_next = vx; g_next = vc; b_next = vm; end
      3'd2: begin r_next = vm; g_next = vc; b_next = vx; end
      3'd3: begin r_next = vm; g_next = vx; b_next = vc; end
      3'd4: begin r_next = vx; g_next = vm; b_next = vc; end
      default: begin r_next = vc; g_next = vm; b_next = vx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    red   <= r_next;
    green <= g_next;
    blue  <= b_next;
  end

endmodule

>>> sv/hsl2rgb_checker.sv
// port-level checks for the hsl to rgb converter core
module hsl2rgb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] red,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] green,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] blue
);

  // every accepted beat comes out after the fixed latency
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hsl2rgb_pkg::PIPE_DEPTH) done)
    else $error("accepted hue produced no result");

  // no result without a beat accepted at the fixed latency before
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hsl2rgb_pkg::PIPE_DEPTH))
    else $error("result without matching accepted hue");

  // the core never holds off input outside reset
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised outside reset");

  // no result in the cycle right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result shown right after reset");

  // a result beat carries known channel values
  a_known_color: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({red, green, blue}))
    else $error("result beat with unknown channel value");

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_checker u_hsl2rgb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .red   (red),
  .green (green),
  .blue  (blue)
);
